>>> sv/insertion_sorter_defines.svh
// assertion macros shared by the insertion sorter rtl
`ifndef INSERTION_SORTER_DEFINES_SVH
`define INSERTION_SORTER_DEFINES_SVH

// generic clocked assertion with explicit clock and active-low reset
`define ISORT_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the default clock and reset of the rtl
`define ISORT_ASSERT(lbl, prop, msg) \
  `ISORT_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> sv/isort_pkg.sv
// types and constants of the insertion sorter
package isort_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef logic signed [31:0] value_t;
  typedef logic [CNT_W-1:0]   count_t;

  // control broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   shift;
    value_t value;
  } cell_ctl_t;

endpackage

>>> sv/isort_cell.sv
// one slot of the insertion chain: compare, take neighbor or new value
module isort_cell (
  input  logic                clk_i,
  input  isort_pkg::cell_ctl_t ctl_i,
  input  logic                valid_i,
  input  logic                prev_valid_i,
  input  logic                prev_gt_i,
  input  isort_pkg::value_t   prev_data_i,
  input  isort_pkg::value_t   next_data_i,
  output isort_pkg::value_t   data_o,
  output logic                gt_o
);
  import isort_pkg::*;

  value_t data_q;
  value_t data_d;

  // stored entry strictly greater than the incoming value moves up
  assign gt_o   = valid_i && (data_q > ctl_i.value);
  assign data_o = data_q;

  always_comb begin
    data_d = data_q;
    if (ctl_i.shift) begin
      data_d = next_data_i;
    end else if (ctl_i.ins) begin
      if (prev_gt_i) begin
        data_d = prev_data_i;
      end else if (gt_o || (!valid_i && prev_valid_i)) begin
        data_d = ctl_i.value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

>>> sv/insertion_sorter.sv
// insertion sorter top level: cell chain, fill count and drain control
//
//  port group   direction  handshake                 payload
//  request in   into       in_valid_i / in_stall_o   value_i, end_of_set_i
//  request out  out of     out_valid_o / out_stall_i sorted_value_o, final_res_o, dropped_o
//
// one value enters the chain per cycle while no set drains; every cell compares against it in parallel
// a set closed by end_of_set_i drains from cell 0, one request per cycle unless out_stall_i holds it
// the input is stalled for the whole drain
// rst_ni clears the fill count, drain flag and overflow flag; cell data has no reset
// out_stall_i freezes the chain, so the head value holds while stalled
`include "insertion_sorter_defines.svh"

module insertion_sorter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  isort_pkg::value_t  value_i,
  input  logic               end_of_set_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output isort_pkg::value_t  sorted_value_o,
  output logic               final_res_o,
  output logic               dropped_o
);
  import isort_pkg::*;

  // handshake and control
  logic      in_acc;
  logic      out_acc;
  logic      full;
  logic      last_out;
  cell_ctl_t ctl;

  count_t fill_q, fill_d;
  logic   drain_q, drain_d;
  logic   ovf_q, ovf_d;

  // chain wiring
  value_t               data [CAPACITY];
  logic [CAPACITY-1:0]  gt;
  logic [CAPACITY-1:0]  valid;

  assign in_stall_o = drain_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = drain_q;
  assign out_acc    = out_valid_o && !out_stall_i;

  assign full     = (fill_q == count_t'(CAPACITY));
  assign last_out = (fill_q == count_t'(1));

  // a full store drops the value and only records the loss
  assign ctl.ins   = in_acc && !full;
  assign ctl.shift = out_acc;
  assign ctl.value = value_i;

  // head of the chain is the smallest entry
  assign sorted_value_o = data[0];
  assign final_res_o    = last_out;
  assign dropped_o      = ovf_q;

  // cell i holds a live entry when it lies below the fill count
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam count_t Idx = count_t'(i);
    logic   prev_valid;
    logic   prev_gt;
    value_t prev_data;
    value_t next_data;

    assign valid[i] = (fill_q > Idx);

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign prev_gt    = 1'b0;
      assign prev_data  = data[0];
    end else begin : g_body
      assign prev_valid = valid[i-1];
      assign prev_gt    = gt[i-1];
      assign prev_data  = data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_data = data[i];
    end else begin : g_inner
      assign next_data = data[i+1];
    end

    isort_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .valid_i     (valid[i]),
      .prev_valid_i(prev_valid),
      .prev_gt_i   (prev_gt),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .data_o      (data[i]),
      .gt_o        (gt[i])
    );
  end

  always_comb begin
    fill_d  = fill_q;
    drain_d = drain_q;
    ovf_d   = ovf_q;
    if (out_acc) begin
      fill_d = fill_q - count_t'(1);
      if (last_out) begin
        drain_d = 1'b0;
        ovf_d   = 1'b0;
      end
    end else if (in_acc) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        fill_d = fill_q + count_t'(1);
      end
      // the closing value is inserted (or dropped on a full store) first, then the set drains
      if (end_of_set_i) begin
        drain_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      drain_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      drain_q <= drain_d;
      ovf_q   <= ovf_d;
    end
  end

  // a loss is recorded on a full store and kept while that set drains
  `ISORT_ASSERT(a_ovf_full, ovf_q |-> (full || drain_q), "overflow flag set without a full store")
  // a drain never starts from an empty store
  `ISORT_ASSERT(a_drain_nonempty, out_valid_o |-> (fill_q != '0), "drain with empty store")
  // after the final result the block is empty and accepting again
  `ISORT_ASSERT(a_final_clears, (out_acc && final_res_o) |=> (!out_valid_o && fill_q == '0 && !dropped_o), "set not cleared after final result")
  // an insert into a store with room grows the fill count by one
  `ISORT_ASSERT(a_fill_grows, ctl.ins |=> (fill_q == $past(fill_q) + count_t'(1)), "fill count did not advance on insert")
  // live entries are kept in ascending order at the head of the chain
  `ISORT_ASSERT(a_head_order, (out_valid_o && !final_res_o) |-> (data[0] <= data[1]), "head of chain out of order")

endmodule

>>> test/insertion_sorter_tb.sv
// self-checking testbench of the insertion sorter: directed, random and backpressure sets
module insertion_sorter_tb;
  import isort_pkg::*;

  localparam value_t VALUE_MAX       = 32'sh7FFF_FFFF;
  localparam value_t VALUE_MIN       = 32'sh8000_0000;
  localparam int     RANDOM_ITEMS    = 200;
  localparam int     HOLD_OFF_CYCLES = 80;
  localparam int     DRAIN_WAIT      = CAPACITY + 8;
  // longest quiet stretch: hold-off plus a full drain behind maximum stalls
  localparam int     WATCHDOG_LIMIT  = 2000;
  localparam int     MAX_REPORTS     = 10;

  // one sorted request as it should leave the block
  typedef struct {
    value_t value;
    logic   final_res;
    logic   dropped;
  } sorted_result_t;

  logic   clk_i        = 1'b0;
  logic   rst_ni       = 1'b0;
  logic   in_valid_i   = 1'b0;
  logic   in_stall_o;
  value_t value_i      = '0;
  logic   end_of_set_i = 1'b0;
  logic   out_valid_o;
  logic   out_stall_i  = 1'b0;
  value_t sorted_value_o;
  logic   final_res_o;
  logic   dropped_o;

  // predictor state: ascending store, fill level and overflow flag of the open set
  value_t         model_store [CAPACITY];
  int             store_fill     = 0;
  logic           store_overflow = 1'b0;
  sorted_result_t pending_sorted [$];

  int   fail_count     = 0;
  int   quiet_cycles   = 0;
  bit   in_idle_on     = 1'b1;
  bit   out_idle_on    = 1'b1;
  int   out_stall_left = 0;
  logic hold_off       = 1'b0;
  event hold_off_start;

  insertion_sorter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .end_of_set_i  (end_of_set_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sorted_value_o(sorted_value_o),
    .final_res_o   (final_res_o),
    .dropped_o     (dropped_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // insert one accepted value; on end of set queue the whole ascending burst
  function automatic void track_request(input value_t v, input logic eos);
    int pos;
    sorted_result_t res;
    if (store_fill >= CAPACITY) begin
      // full store: value is lost, every result of this set reports it
      store_overflow = 1'b1;
    end else begin
      pos = store_fill;
      // equal keys stay put, so arrival order is kept
      while (pos > 0 && model_store[pos-1] > v) begin
        model_store[pos] = model_store[pos-1];
        pos--;
      end
      model_store[pos] = v;
      store_fill++;
    end
    if (eos) begin
      for (int k = 0; k < store_fill; k++) begin
        res.value     = model_store[k];
        res.final_res = (k == store_fill - 1);
        res.dropped   = store_overflow;
        pending_sorted.push_back(res);
      end
      store_fill     = 0;
      store_overflow = 1'b0;
    end
  endfunction

  // mix of full-range, clustered (many equal keys) and near-extreme values
  function automatic value_t rand_value();
    value_t v;
    case ($urandom_range(0, 5))
      0: v = value_t'($urandom_range(0, 16)) - 8;
      1: v = VALUE_MAX - value_t'($urandom_range(0, 3));
      2: v = VALUE_MIN + value_t'($urandom_range(0, 3));
      default: v = value_t'($urandom);
    endcase
    return v;
  endfunction

  // offer one request, hold it until accepted, then update the prediction
  task automatic send_request(input value_t v, input logic eos);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    value_i      <= v;
    end_of_set_i <= eos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_request(v, eos);
  endtask

  task automatic send_random_set(input int size);
    for (int i = 0; i < size; i++) begin
      send_request(rand_value(), i == size - 1);
    end
  endtask

  // single-element set, then full-scale extremes with repeated keys
  task automatic test_extremes();
    in_idle_on = 1'b1;
    send_request(VALUE_MIN, 1'b1);
    send_request(VALUE_MAX, 1'b0);
    send_request(VALUE_MIN, 1'b0);
    send_request('0, 1'b0);
    send_request('1, 1'b0);
    send_request(VALUE_MAX, 1'b0);
    send_request(VALUE_MIN, 1'b0);
    send_request(value_t'(1), 1'b1);
  endtask

  // descending values force the longest shifts; the closing value itself is dropped
  task automatic test_overflow();
    for (int i = 0; i <= CAPACITY; i++) begin
      send_request(value_t'(300 - 20 * i), i == CAPACITY);
    end
  endtask

  // random sets, mostly within capacity, some overflowing
  task automatic test_random_sets(input int n_items);
    int sent;
    int size;
    sent = 0;
    while (sent < n_items) begin
      in_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 5) == 0) size = $urandom_range(CAPACITY + 1, CAPACITY + 4);
      else size = $urandom_range(1, CAPACITY);
      send_random_set(size);
      sent += size;
    end
  endtask

  // receiver holds off while the sender keeps pushing, so the input backs up
  task automatic test_backpressure();
    in_idle_on = 1'b0;
    -> hold_off_start;
    repeat (3) send_random_set(8);
    in_idle_on = 1'b1;
  endtask

  // sender goes quiet until every result is out, then resumes
  task automatic test_quiet_pause();
    send_random_set(10);
    in_valid_i <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk_i);
    send_random_set(10);
  endtask

  // receiver: checks each accepted request against the oldest expectation,
  // then draws its stall for the next one
  always @(posedge clk_i) begin
    sorted_result_t exp_res;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_sorted.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result: value %0d final %0b dropped %0b",
                     sorted_value_o, final_res_o, dropped_o);
        end else begin
          exp_res = pending_sorted.pop_front();
          if (sorted_value_o !== exp_res.value || final_res_o !== exp_res.final_res ||
              dropped_o !== exp_res.dropped) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                       exp_res.value, exp_res.final_res, exp_res.dropped,
                       sorted_value_o, final_res_o, dropped_o);
          end
        end
        // new stall mode per set so some bursts drain without gaps
        if (final_res_o) out_idle_on = ($urandom_range(0, 2) != 0);
        out_stall_left = out_idle_on ? $urandom_range(0, 19) : 0;
      end else if (out_stall_left != 0) begin
        out_stall_left--;
      end
      out_stall_i <= (out_stall_left != 0) || hold_off;
    end
  end

  // long receiver hold-off, counted here so the sender keeps running
  always begin
    @(hold_off_start);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // watchdog: too long without any request moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_overflow();
    test_random_sets(RANDOM_ITEMS);
    test_backpressure();
    test_quiet_pause();
    in_valid_i <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk_i);
    // catch any stray request after the last expected one
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
